@@ rtl/trlb_pkg.sv @@
// Package for the terminal receive line buffer.
// Holds character codes, result kinds and configuration register indexes.
// No dependencies.
package trlb_pkg;

  typedef logic [7:0] char_t;

  localparam char_t CH_BS = 8'h08;
  localparam char_t CH_LF = 8'h0A;
  localparam char_t CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LINE_EDIT   = 2'd0;
  localparam cfg_idx_t REG_ECHO_ENABLE = 2'd1;

endpackage

@@ rtl/trlb_in_if.sv @@
// Input channel of the terminal receive line buffer: op and received byte.
// Depends on trlb_pkg.
interface trlb_in_if;
  import trlb_pkg::*;
  logic  valid;
  logic  ready;
  logic  op;
  char_t rx_byte;
  modport source (output valid, op, rx_byte, input ready);
  modport sink (input valid, op, rx_byte, output ready);
endinterface

@@ rtl/trlb_out_if.sv @@
// Result channel of the terminal receive line buffer: kind, data, last.
// Depends on trlb_pkg.
interface trlb_out_if;
  import trlb_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  char_t data;
  logic  last;
  modport source (output valid, kind, data, last, input ready);
  modport sink (input valid, kind, data, last, output ready);
endinterface

@@ rtl/trlb_cfg_if.sv @@
// Configuration write channel of the terminal receive line buffer.
// Depends on trlb_pkg.
interface trlb_cfg_if;
  import trlb_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  logic     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/terminal_rx_line_buffer_top.sv @@
// Terminal receive line buffer: ring store with backspace, CR/LF merging and echo.
// First result: registered, valid in the cycle after the input transfer.
// Input flow: a new item is taken only while the single result register is empty; an
// echoed newline holds it for CR then LF, and an item without result does not hold it.
// Reset: indices, previous character and result control cleared, both config
// bits set to 1; the line store is not cleared. Depends on trlb_pkg and the interfaces.
module terminal_rx_line_buffer_top #(
  parameter int BUFFER_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  trlb_in_if.sink    rx_in,
  trlb_out_if.source res_out,
  trlb_cfg_if.sink   cfg
);
  import trlb_pkg::*;

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);

  char_t            line_store [BUFFER_DEPTH];
  char_t            rd_q;

  logic [IDX_W-1:0] read_index, read_index_next;
  logic [IDX_W-1:0] write_index, write_index_next;
  char_t            prev_char, prev_char_next;
  logic             line_edit, echo_enable;

  logic             out_valid, out_valid_next;
  kind_t            out_kind, out_kind_next;
  char_t            out_data, out_data_next;
  logic             out_last, out_last_next;
  logic             out_from_mem, out_from_mem_next;
  logic             pend_valid, pend_valid_next;

  logic             in_fire, out_fire, cfg_fire;
  logic             store_we;
  char_t            store_wdata;
  logic             buf_empty;
  char_t            cs;
  logic [IDX_W-1:0] wi_inc, ri_inc, wi_dec;

  assign rx_in.ready  = !out_valid;
  assign cfg.ready    = 1'b1;
  assign in_fire      = rx_in.valid && rx_in.ready;
  assign out_fire     = out_valid && res_out.ready;
  assign cfg_fire     = cfg.valid && cfg.ready;

  assign res_out.valid = out_valid;
  assign res_out.kind  = out_kind;
  assign res_out.data  = out_from_mem ? rd_q : out_data;
  assign res_out.last  = out_last;

  assign buf_empty = (read_index == write_index);
  assign wi_inc    = (write_index == IDX_LAST) ? '0 : write_index + 1'b1;
  assign ri_inc    = (read_index == IDX_LAST) ? '0 : read_index + 1'b1;
  assign wi_dec    = (write_index == '0) ? IDX_LAST : write_index - 1'b1;

  always_comb begin
    read_index_next   = read_index;
    write_index_next  = write_index;
    prev_char_next    = prev_char;
    out_valid_next    = out_valid;
    out_kind_next     = out_kind;
    out_data_next     = out_data;
    out_last_next     = out_last;
    out_from_mem_next = out_from_mem;
    pend_valid_next   = pend_valid;
    store_we          = 1'b0;
    store_wdata       = rx_in.rx_byte;
    cs                = rx_in.rx_byte;

    if (out_fire) begin
      if (pend_valid) begin
        out_kind_next     = KIND_ECHO;
        out_data_next     = CH_LF;
        out_last_next     = 1'b1;
        out_from_mem_next = 1'b0;
        pend_valid_next   = 1'b0;
      end else begin
        out_valid_next = 1'b0;
      end
    end

    if (in_fire) begin
      if (rx_in.op) begin
        out_valid_next    = 1'b1;
        out_last_next     = 1'b1;
        out_data_next     = '0;
        if (buf_empty) begin
          out_kind_next     = KIND_EMPTY;
          out_from_mem_next = 1'b0;
        end else begin
          out_kind_next     = KIND_DATA;
          out_from_mem_next = 1'b1;
          read_index_next   = ri_inc;
        end
      end else if (line_edit && rx_in.rx_byte == CH_BS) begin
        if (!buf_empty) begin
          write_index_next = wi_dec;
        end
        if (echo_enable) begin
          out_valid_next    = 1'b1;
          out_kind_next     = KIND_ECHO;
          out_data_next     = CH_BS;
          out_last_next     = 1'b1;
          out_from_mem_next = 1'b0;
        end
      end else if (line_edit &&
                   ((rx_in.rx_byte == CH_LF && prev_char == CH_CR) ||
                    (rx_in.rx_byte == CH_CR && prev_char == CH_LF))) begin
        // drop merged CR/LF
      end else begin
        if (line_edit) begin
          prev_char_next = rx_in.rx_byte;
          if (rx_in.rx_byte == CH_CR) begin
            cs = CH_LF;
          end
        end
        store_we         = 1'b1;
        store_wdata      = cs;
        write_index_next = wi_inc;
        if (wi_inc == read_index) begin
          read_index_next = ri_inc;
        end
        if (echo_enable) begin
          out_valid_next    = 1'b1;
          out_kind_next     = KIND_ECHO;
          out_from_mem_next = 1'b0;
          if (line_edit && cs == CH_LF) begin
            out_data_next   = CH_CR;
            out_last_next   = 1'b0;
            pend_valid_next = 1'b1;
          end else begin
            out_data_next = cs;
            out_last_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      line_store[write_index] <= store_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && rx_in.op) begin
      rd_q <= line_store[read_index];
    end
  end

  always_ff @(posedge clk) begin
    out_kind <= out_kind_next;
    out_data <= out_data_next;
    out_last <= out_last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index   <= '0;
      write_index  <= '0;
      prev_char    <= '0;
      out_valid    <= 1'b0;
      out_from_mem <= 1'b0;
      pend_valid   <= 1'b0;
      line_edit    <= 1'b1;
      echo_enable  <= 1'b1;
    end else begin
      read_index   <= read_index_next;
      write_index  <= write_index_next;
      prev_char    <= prev_char_next;
      out_valid    <= out_valid_next;
      out_from_mem <= out_from_mem_next;
      pend_valid   <= pend_valid_next;
      if (cfg_fire && cfg.index == REG_LINE_EDIT) begin
        line_edit <= cfg.data;
      end
      if (cfg_fire && cfg.index == REG_ECHO_ENABLE) begin
        echo_enable <= cfg.data;
      end
    end
  end

  a_pend_has_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("pending LF without a result in the output register");

  a_mem_is_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_from_mem) |-> (out_kind == KIND_DATA && out_last))
    else $error("store data shown on a result that is not read data");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.ready && !res_out.last) |=>
      (res_out.valid && res_out.kind == KIND_ECHO && res_out.data == CH_LF &&
       res_out.last))
    else $error("echoed CR not followed by LF");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    rx_in.ready |-> (!res_out.valid && !pend_valid))
    else $error("input taken while a result is outstanding");

endmodule
